// File: sv/mmu_pkg.sv
`timescale 1ns / 1ps

package mmu_pkg;

  localparam int ELEM_W = 32;
  localparam int ACC_W = 64;
  localparam int DIM_REG_W = 4;
  localparam int IDX_W = 3;
  localparam int ADDR_W_MAX = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_OF_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_OF_B = 2'd2;

  localparam logic [DIM_REG_W-1:0] DIM_RESET = 4'd8;

  localparam logic signed [ACC_W-1:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] ACC_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic             first;
    logic             last;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             run_last;
  } mmu_tag_t;

  typedef struct packed {
    logic                  wr_a;
    logic                  wr_b;
    logic [ADDR_W_MAX-1:0] wr_addr;
    logic                  rd_en;
    logic [ADDR_W_MAX-1:0] rd_addr_a;
    logic [ADDR_W_MAX-1:0] rd_addr_b;
    mmu_tag_t              tag;
  } mmu_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_busy;
  } mmu_sts_t;

endpackage

// File: sv/mmu_ctrl.sv
`timescale 1ns / 1ps

module mmu_ctrl import mmu_pkg::*; #(
  parameter int MAX_DIM = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_REG_W-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_which,
  output mmu_cmd_t             cmd,
  input  mmu_sts_t             sts
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int KW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  localparam logic [1:0] S_LOAD = 2'd0;
  localparam logic [1:0] S_WAIT = 2'd1;
  localparam logic [1:0] S_ISSUE = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [DIM_REG_W-1:0] rows_r, inner_r, cols_r;
  logic [CW-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic [KW-1:0] k_r, k_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [AW-1:0] row_base_r, row_base_nxt, b_addr_r, b_addr_nxt;

  logic [DW-1:0] m_dim, n_dim, p_dim;
  logic [CW-1:0] size_a, size_b;
  logic accept, wr_a, wr_b, k_last, i_last, j_last;

  function automatic logic [DW-1:0] clamp_dim(input logic [DIM_REG_W-1:0] d);
    logic [DW-1:0] r;
    if (d == '0) begin
      r = DW'(1);
    end else if (d > MAX_DIM) begin
      r = DW'(MAX_DIM);
    end else begin
      r = DW'(d);
    end
    return r;
  endfunction

  assign m_dim = clamp_dim(rows_r);
  assign n_dim = clamp_dim(inner_r);
  assign p_dim = clamp_dim(cols_r);
  assign size_a = CW'(m_dim) * CW'(n_dim);
  assign size_b = CW'(n_dim) * CW'(p_dim);

  assign cfg_ready = 1'b1;
  assign in_ready = (state_r == S_LOAD);
  assign accept = in_valid && in_ready;
  assign wr_a = accept && !in_which && (cnt_a_r < size_a);
  assign wr_b = accept && in_which && (cnt_b_r < size_b);

  assign k_last = (k_r == KW'(n_dim - 1'b1));
  assign i_last = (i_r == KW'(m_dim - 1'b1));
  assign j_last = (j_r == KW'(p_dim - 1'b1));

  always_comb begin
    state_nxt = state_r;
    cnt_a_nxt = cnt_a_r + CW'(wr_a);
    cnt_b_nxt = cnt_b_r + CW'(wr_b);
    k_nxt = k_r;
    i_nxt = i_r;
    j_nxt = j_r;
    row_base_nxt = row_base_r;
    b_addr_nxt = b_addr_r;
    case (state_r)
      S_LOAD: begin
        if (accept && (cnt_a_nxt >= size_a) && (cnt_b_nxt >= size_b)) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (!sts.pipe_busy && !sts.out_busy) begin
          state_nxt = S_ISSUE;
          k_nxt = '0;
          b_addr_nxt = AW'(j_r);
        end
      end
      S_ISSUE: begin
        if (!k_last) begin
          k_nxt = k_r + 1'b1;
          b_addr_nxt = b_addr_r + AW'(p_dim);
        end else begin
          k_nxt = '0;
          state_nxt = S_WAIT;
          if (j_last) begin
            j_nxt = '0;
            if (i_last) begin
              i_nxt = '0;
              row_base_nxt = '0;
              cnt_a_nxt = '0;
              cnt_b_nxt = '0;
              state_nxt = S_LOAD;
            end else begin
              i_nxt = i_r + 1'b1;
              row_base_nxt = row_base_r + AW'(n_dim);
            end
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      rows_r <= DIM_RESET;
      inner_r <= DIM_RESET;
      cols_r <= DIM_RESET;
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      k_r <= '0;
      i_r <= '0;
      j_r <= '0;
      row_base_r <= '0;
      b_addr_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_a_r <= cnt_a_nxt;
      cnt_b_r <= cnt_b_nxt;
      k_r <= k_nxt;
      i_r <= i_nxt;
      j_r <= j_nxt;
      row_base_r <= row_base_nxt;
      b_addr_r <= b_addr_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_ROWS_OF_A: rows_r <= cfg_data;
          REG_INNER_SIZE: inner_r <= cfg_data;
          REG_COLS_OF_B: cols_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    cmd.wr_a = wr_a;
    cmd.wr_b = wr_b;
    cmd.wr_addr = ADDR_W_MAX'(in_which ? cnt_b_r[AW-1:0] : cnt_a_r[AW-1:0]);
    cmd.rd_en = (state_r == S_ISSUE);
    cmd.rd_addr_a = ADDR_W_MAX'(row_base_r + AW'(k_r));
    cmd.rd_addr_b = ADDR_W_MAX'(b_addr_r);
    cmd.tag.first = (k_r == '0);
    cmd.tag.last = k_last;
    cmd.tag.row = IDX_W'(i_r);
    cmd.tag.col = IDX_W'(j_r);
    cmd.tag.run_last = i_last && j_last;
  end

endmodule

// File: sv/mmu_datapath.sv
`timescale 1ns / 1ps

module mmu_datapath import mmu_pkg::*; #(
  parameter int MAX_DIM = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mmu_cmd_t                cmd,
  input  logic [ELEM_W-1:0]       in_data,
  output mmu_sts_t                sts,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [ACC_W-1:0] out_value,
  output logic [IDX_W-1:0]        out_row,
  output logic [IDX_W-1:0]        out_col,
  output logic                    out_last
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [ELEM_W-1:0] store_a_mem [DEPTH];
  logic [ELEM_W-1:0] store_b_mem [DEPTH];

  logic signed [ELEM_W-1:0] a_q_r, b_q_r;
  logic signed [ACC_W-1:0] prod_r, acc_r, out_value_r, sum;
  mmu_tag_t tag1_r, tag2_r;
  logic v1_r, v2_r, out_valid_r;
  logic [IDX_W-1:0] out_row_r, out_col_r;
  logic out_last_r, done;

  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0] a,
    input logic signed [ACC_W-1:0] b
  );
    logic signed [ACC_W-1:0] s;
    s = a + b;
    if ((a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1])) begin
      s = a[ACC_W-1] ? ACC_MIN : ACC_MAX;
    end
    return s;
  endfunction

  // element stores, one write and one registered read each
  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      store_a_mem[cmd.wr_addr[AW-1:0]] <= in_data;
    end
    if (cmd.wr_b) begin
      store_b_mem[cmd.wr_addr[AW-1:0]] <= in_data;
    end
    if (cmd.rd_en) begin
      a_q_r <= store_a_mem[cmd.rd_addr_a[AW-1:0]];
      b_q_r <= store_b_mem[cmd.rd_addr_b[AW-1:0]];
    end
  end

  assign sum = tag2_r.first ? prod_r : sat_add(acc_r, prod_r);
  assign done = v2_r && tag2_r.last;

  always_ff @(posedge clk) begin
    tag1_r <= cmd.tag;
    tag2_r <= tag1_r;
    prod_r <= a_q_r * b_q_r;
    if (v2_r) begin
      acc_r <= sum;
    end
    if (done) begin
      out_value_r <= sum;
      out_row_r <= tag2_r.row;
      out_col_r <= tag2_r.col;
      out_last_r <= tag2_r.run_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd_en;
      v2_r <= v1_r;
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.pipe_busy = v1_r || v2_r;
  assign sts.out_busy = out_valid_r;

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_row = out_row_r;
  assign out_col = out_col_r;
  assign out_last = out_last_r;

endmodule

// File: sv/matrix_multiply_unit.sv
`timescale 1ns / 1ps

// Signed fixed-point matrix multiply C = A * B. Elements of A and B (Q16.16) are
// streamed in row-major order, tagged by in_tuser, at one item per cycle; items
// beyond a matrix's configured size are dropped. Once both are loaded the input
// stops accepting and each C[i][j] (Q32.32, saturating sum) leaves in row-major
// order with tlast on the final element. One shared multiply-accumulate computes
// each result, reading one element pair per cycle from the two stores, and the
// next result starts only once the previous one has been taken. Dimension
// registers read as 0 act as 1 and above MAX_DIM act as MAX_DIM.
module matrix_multiply_unit import mmu_pkg::*; #(
  parameter int MAX_DIM = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_REG_W-1:0] cfg_data,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,   // element_value
  input  logic                 in_tuser,   // which_matrix
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [71:0]          out_tdata,  // product_value, result_row, result_col
  output logic                 out_tlast
);

  mmu_cmd_t cmd;
  mmu_sts_t sts;
  logic signed [ACC_W-1:0] product_value;
  logic [IDX_W-1:0] result_row, result_col;

  mmu_ctrl #(
    .MAX_DIM(MAX_DIM)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .in_which(in_tuser),
    .cmd(cmd),
    .sts(sts)
  );

  mmu_datapath #(
    .MAX_DIM(MAX_DIM)
  ) u_datapath (
    .clk(clk),
    .rst_n(rst_n),
    .cmd(cmd),
    .in_data(in_tdata),
    .sts(sts),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_value(product_value),
    .out_row(result_row),
    .out_col(result_col),
    .out_last(out_tlast)
  );

  assign out_tdata = {2'b00, result_col, result_row, product_value};

endmodule

// File: sim/tb_matrix_multiply_unit.sv
`timescale 1ns / 1ps

module tb_matrix_multiply_unit;
  import mmu_pkg::*;

  localparam bit MAT_A = 1'b0;
  localparam bit MAT_B = 1'b1;
  localparam int MAX_N = 8;
  localparam int SETTLE_CYCLES = 24;

  typedef struct {
    bit [63:0] value;
    bit [2:0]  row;
    bit [2:0]  col;
    bit        last;
  } c_elem_t;

  class gemm_scoreboard;
    bit [3:0]         rows_reg;
    bit [3:0]         inner_reg;
    bit [3:0]         cols_reg;
    bit signed [31:0] a_elems[64];
    bit signed [31:0] b_elems[64];
    int               a_loaded;
    int               b_loaded;
    c_elem_t          pending_products[$];
    int               fails;

    function new();
      rows_reg  = DIM_RESET;
      inner_reg = DIM_RESET;
      cols_reg  = DIM_RESET;
      a_loaded  = 0;
      b_loaded  = 0;
      fails     = 0;
    endfunction

    function int eff_dim(bit [3:0] v);
      if (v == 0) return 1;
      if (v > MAX_N) return MAX_N;
      return int'(v);
    endfunction

    function void set_dim(logic [CFG_IDX_W-1:0] idx, bit [3:0] v);
      case (idx)
        REG_ROWS_OF_A:  rows_reg = v;
        REG_INNER_SIZE: inner_reg = v;
        REG_COLS_OF_B:  cols_reg = v;
        default: ;
      endcase
    endfunction

    function int need_a();
      int n;
      n = eff_dim(rows_reg) * eff_dim(inner_reg) - a_loaded;
      return (n > 0) ? n : 0;
    endfunction

    function int need_b();
      int n;
      n = eff_dim(inner_reg) * eff_dim(cols_reg) - b_loaded;
      return (n > 0) ? n : 0;
    endfunction

    function void compute_products();
      int      m;
      int      n;
      int      p;
      longint  acc;
      longint  prod;
      longint  s;
      c_elem_t e;
      m = eff_dim(rows_reg);
      n = eff_dim(inner_reg);
      p = eff_dim(cols_reg);
      for (int i = 0; i < m; i++) begin
        for (int j = 0; j < p; j++) begin
          acc = 0;
          for (int k = 0; k < n; k++) begin
            prod = longint'(a_elems[(i * n + k) % 64]) * longint'(b_elems[(k * p + j) % 64]);
            s = acc + prod;
            if (acc >= 0 && prod >= 0 && s < 0) s = ACC_MAX;
            else if (acc < 0 && prod < 0 && s >= 0) s = ACC_MIN;
            acc = s;
          end
          e.value = acc;
          e.row   = 3'(i);
          e.col   = 3'(j);
          e.last  = (i == m - 1) && (j == p - 1);
          pending_products.push_back(e);
        end
      end
    endfunction

    // returns 1 when the item was stored, 0 when dropped
    function bit note_element(bit which, bit [31:0] value);
      bit stored;
      stored = 1'b0;
      if (which == MAT_A) begin
        if (need_a() > 0) begin
          a_elems[a_loaded % 64] = value;
          a_loaded++;
          stored = 1'b1;
        end
      end else begin
        if (need_b() > 0) begin
          b_elems[b_loaded % 64] = value;
          b_loaded++;
          stored = 1'b1;
        end
      end
      if (need_a() == 0 && need_b() == 0) begin
        compute_products();
        a_loaded = 0;
        b_loaded = 0;
      end
      return stored;
    endfunction

    function void check_result(logic [71:0] tdata, logic tlast);
      c_elem_t e;
      if (pending_products.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected result item: value %h row %0d col %0d last %b",
                   tdata[63:0], tdata[66:64], tdata[69:67], tlast);
        return;
      end
      e = pending_products.pop_front();
      if (tdata[63:0] !== e.value || tdata[66:64] !== e.row || tdata[69:67] !== e.col ||
          tlast !== e.last) begin
        fails++;
        if (fails <= 10)
          $display("mismatch at C[%0d][%0d]: expected %h/%0d/%0d/%b, got %h/%0d/%0d/%b",
                   e.row, e.col, e.value, e.row, e.col, e.last,
                   tdata[63:0], tdata[66:64], tdata[69:67], tlast);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_REG_W-1:0] cfg_data;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [31:0]          in_tdata;
  logic                 in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [71:0]          out_tdata;
  logic                 out_tlast;

  gemm_scoreboard sb;
  bit             idle_on;
  int             useful;

  matrix_multiply_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int n;
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 18);
        out_tready <= 1'b0;
      end else begin
        n = $urandom_range(1, 24);
        out_tready <= 1'b1;
      end
      repeat (n) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
  end

  function automatic bit [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic bit [3:0] rand_dim();
    case ($urandom_range(0, 9))
      0: return 4'd0;
      1: return 4'($urandom_range(9, 15));
      2: return 4'd8;
      default: return 4'($urandom_range(1, 4));
    endcase
  endfunction

  task automatic send_elem(input bit which, input bit [31:0] value);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= which;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (sb.note_element(which, value)) useful++;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending_products.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_dims(input bit [3:0] r, input bit [3:0] n, input bit [3:0] c);
    bit [3:0]             vals[3];
    logic [CFG_IDX_W-1:0] regs[3];
    vals = '{r, n, c};
    regs = '{REG_ROWS_OF_A, REG_INNER_SIZE, REG_COLS_OF_B};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.set_dim(regs[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // one load of both matrices in random interleaving, optionally cut short
  task automatic load_matrices(input bit partial);
    int  na;
    int  nb;
    int  stop_at;
    int  sent;
    bit  which;
    na = sb.need_a();
    nb = sb.need_b();
    stop_at = (partial && na + nb > 1) ? $urandom_range(1, na + nb - 1) : na + nb;
    sent = 0;
    while (na + nb > 0 && sent < stop_at) begin
      if ((na == 0 || nb == 0) && $urandom_range(0, 7) == 0)
        send_elem((na == 0) ? MAT_A : MAT_B, rand_value());
      which = (nb == 0) ? MAT_A : (na == 0) ? MAT_B : bit'($urandom_range(0, 1));
      send_elem(which, rand_value());
      if (which == MAT_A) na--;
      else nb--;
      sent++;
    end
  endtask

  initial begin
    sb = new();
    idle_on = 1'b1;
    useful = 0;
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_ROWS_OF_A;
    cfg_data <= '0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= MAT_A;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero rows read as one, extra element of a full matrix dropped
    write_dims(4'd0, 4'd1, 4'd1);
    send_elem(MAT_A, 32'h7FFF_FFFF);
    send_elem(MAT_A, 32'h8000_0000);
    send_elem(MAT_B, 32'h7FFF_FFFF);
    settle();

    // positive saturation
    write_dims(4'd1, 4'd2, 4'd1);
    send_elem(MAT_A, 32'h8000_0000);
    send_elem(MAT_A, 32'h8000_0000);
    send_elem(MAT_B, 32'h8000_0000);
    send_elem(MAT_B, 32'h8000_0000);
    settle();

    // negative saturation
    write_dims(4'd1, 4'd3, 4'd1);
    for (int i = 0; i < 3; i++) send_elem(MAT_A, 32'h8000_0000);
    for (int i = 0; i < 3; i++) send_elem(MAT_B, 32'h7FFF_FFFF);
    settle();

    // oversized rows clamp to eight, then shrink while A is half loaded
    write_dims(4'd15, 4'd0, 4'd1);
    send_elem(MAT_A, 32'h0001_0000);
    send_elem(MAT_A, 32'hFFFF_0000);
    send_elem(MAT_A, 32'h0000_0000);
    send_elem(MAT_A, 32'h0000_0001);
    settle();
    write_dims(4'd2, 4'd0, 4'd1);
    send_elem(MAT_B, 32'hFFFF_FFFF);
    settle();

    useful = 0;
    while (useful < 90) begin
      idle_on = ($urandom_range(0, 3) != 0);
      write_dims(rand_dim(), rand_dim(), rand_dim());
      load_matrices($urandom_range(0, 5) == 0);
      settle();
    end

    idle_on = 1'b0;
    write_dims(4'd8, 4'd2, 4'd8);
    load_matrices(1'b0);
    settle();

    if (sb.fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/mmu_pkg.sv
sv/mmu_ctrl.sv
sv/mmu_datapath.sv
sv/matrix_multiply_unit.sv
sim/tb_matrix_multiply_unit.sv
